// File: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Payload structs, calibration fields, stage-to-stage records and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int RAW_W       = 20;
  localparam int FINE_W      = 25;
  localparam int A_W         = 26;
  localparam int DEN_W       = 31;
  localparam int DIV_STEPS   = 64;
  localparam int FINE_OFFSET = 128000;
  localparam int PRESS_FULL  = 1048576;
  localparam int PRESS_SCALE = 3125;

  typedef enum logic [1:0] {
    REG_CALIB_TEMP = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_HIGH = 2'd2,
    REG_PRESS_LAST = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_temp;
    logic [RAW_W-1:0] raw_press;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_value;
    logic               press_invalid;
  } ptc_out_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } ptc_calib_t;

  // Temperature section result: compensated temperature and offset fine value.
  typedef struct packed {
    logic signed [31:0]    temp;
    logic signed [A_W-1:0] a;
    logic [RAW_W-1:0]      raw_press;
  } ptc_tmp_t;

  // Divider operands as magnitudes plus the sign of the quotient.
  typedef struct packed {
    logic [63:0]       num_mag;
    logic [DEN_W-1:0]  den_mag;
    logic              neg;
    logic              invalid;
    logic signed [31:0] temp;
  } ptc_dvop_t;

  typedef struct packed {
    logic [63:0]        quo;
    logic               neg;
    logic               invalid;
    logic signed [31:0] temp;
  } ptc_quo_t;

endpackage

// File: rtl/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp: temperature compensation pipeline
// Five stages from raw temperature to the fine value, the temperature in
// hundredths of a degree and the offset fine value used by the pressure path.
// ----------------------------------------------------------------------------
module ptc_temp import ptc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  ptc_in_t    in_data,
  input  ptc_calib_t calib,
  output logic       out_vld,
  output ptc_tmp_t   out_data
);

  logic [4:0] vld;
  logic [RAW_W-1:0] rp [5];

  logic signed [18:0] d1, d1_next;
  logic signed [17:0] d2, d2_next;
  logic signed [34:0] v1p, v1p_next;
  logic signed [35:0] sq_full;
  logic [31:0]        sq, sq_next;
  logic signed [23:0] v1, v1_next;
  logic signed [36:0] v2p, v2p_next;
  logic signed [FINE_W-1:0] fine, fine_next;
  logic signed [27:0] scaled;
  logic signed [31:0] temp, temp_next;
  logic signed [A_W-1:0] a, a_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_vld};
    end
  end

  assign d1_next = $signed({2'b00, in_data.raw_temp[19:3]}) - $signed({2'b00, calib.t1, 1'b0});
  assign d2_next = $signed({2'b00, in_data.raw_temp[19:4]}) - $signed({2'b00, calib.t1});

  assign v1p_next = d1 * $signed(calib.t2);
  assign sq_full  = d2 * d2;
  assign sq_next  = sq_full[31:0];

  assign v1_next  = v1p[34:11];
  assign v2p_next = $signed({1'b0, sq[31:12]}) * $signed(calib.t3);

  assign fine_next = $signed({v1[23], v1}) + $signed({{2{v2p[36]}}, v2p[36:14]});

  // Temperature is (fine * 5 + 128) >> 8, formed as fine * 4 + fine.
  assign scaled    = $signed({fine[FINE_W-1], fine, 2'b00})
                   + $signed({{3{fine[FINE_W-1]}}, fine}) + 28'sd128;
  assign temp_next = {{12{scaled[27]}}, scaled[27:8]};
  assign a_next    = $signed({fine[FINE_W-1], fine}) - A_W'(FINE_OFFSET);

  always_ff @(posedge clk) begin
    if (en) begin
      rp[0] <= in_data.raw_press;
      for (int i = 1; i < 5; i++) begin
        rp[i] <= rp[i-1];
      end
      d1   <= d1_next;
      d2   <= d2_next;
      v1p  <= v1p_next;
      sq   <= sq_next;
      v1   <= v1_next;
      v2p  <= v2p_next;
      fine <= fine_next;
      temp <= temp_next;
      a    <= a_next;
    end
  end

  assign out_vld            = vld[4];
  assign out_data.temp      = temp;
  assign out_data.a         = a;
  assign out_data.raw_press = rp[4];

endmodule

// File: rtl/ptc_coef.sv
// ----------------------------------------------------------------------------
// ptc_coef: pressure coefficient pipeline
// Seven stages that form the divisor and the dividend of the pressure
// formula in wrapping 64-bit arithmetic and hand them on as magnitudes.
// ----------------------------------------------------------------------------
module ptc_coef import ptc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  ptc_tmp_t   in_data,
  input  ptc_calib_t calib,
  output logic       out_vld,
  output ptc_dvop_t  out_data
);

  logic [6:0] vld;
  logic signed [31:0] tp [7];
  logic [RAW_W-1:0]   rp [3];

  // Stage 1: square and linear terms of the offset fine value.
  logic signed [51:0] aa_full;
  logic [51:0]        aa;
  logic signed [41:0] ap5, ap5_next, ap2, ap2_next;
  // Stage 2: partial products of the square with P6 and P3.
  logic signed [42:0] m6l, m6l_next, m6h, m6h_next, m3l, m3l_next, m3h, m3h_next;
  logic signed [41:0] ap5_2, ap2_2;
  // Stage 3: offset term b and the P3 product.
  logic [63:0] b, b_next, s3, s3_next;
  logic signed [41:0] ap2_3;
  // Stage 4: operand of the P1 product and the raw dividend.
  logic signed [63:0] s3_sh;
  logic [20:0] dp;
  logic [63:0] x, x_next, pn, pn_next;
  // Stage 5: split products.
  logic [47:0] xl_p1, xl_p1_next, xh_full;
  logic [31:0] xh_p1, xh_p1_next;
  logic [43:0] nl_k, nl_k_next, nh_full;
  logic [31:0] nh_k, nh_k_next;
  // Stage 6: divisor and dividend.
  logic [63:0] prod, num, num_next;
  logic [DEN_W-1:0] den, den_next;
  // Stage 7: magnitudes and sign.
  logic [63:0]      num_mag, num_mag_next;
  logic [DEN_W-1:0] den_mag, den_mag_next;
  logic             neg, neg_next, invalid, invalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_vld};
    end
  end

  assign aa_full  = in_data.a * in_data.a;
  assign ap5_next = in_data.a * $signed(calib.p5);
  assign ap2_next = in_data.a * $signed(calib.p2);

  assign m6l_next = $signed({1'b0, aa[25:0]}) * $signed(calib.p6);
  assign m6h_next = $signed({1'b0, aa[51:26]}) * $signed(calib.p6);
  assign m3l_next = $signed({1'b0, aa[25:0]}) * $signed(calib.p3);
  assign m3h_next = $signed({1'b0, aa[51:26]}) * $signed(calib.p3);

  assign b_next  = {{21{m6l[42]}}, m6l} + ({{21{m6h[42]}}, m6h} << 26)
                 + ({{22{ap5_2[41]}}, ap5_2} << 17) + ({{48{calib.p4[15]}}, calib.p4} << 35);
  assign s3_next = {{21{m3l[42]}}, m3l} + ({{21{m3h[42]}}, m3h} << 26);

  assign s3_sh   = $signed(s3) >>> 8;
  assign x_next  = 64'h0000_8000_0000_0000 + s3_sh + ({{22{ap2_3[41]}}, ap2_3} << 12);
  assign dp      = 21'(PRESS_FULL) - {1'b0, rp[2]};
  assign pn_next = ({43'd0, dp} << 31) - b;

  assign xl_p1_next = x[31:0] * calib.p1;
  assign xh_full    = x[63:32] * calib.p1;
  assign xh_p1_next = xh_full[31:0];
  assign nl_k_next  = pn[31:0] * 12'(PRESS_SCALE);
  assign nh_full    = pn[63:32] * 12'(PRESS_SCALE);
  assign nh_k_next  = nh_full[31:0];

  assign prod     = {16'd0, xl_p1} + {xh_p1, 32'd0};
  assign den_next = prod[63:33];
  assign num_next = {20'd0, nl_k} + {nh_k, 32'd0};

  assign neg_next     = num[63] ^ den[DEN_W-1];
  assign num_mag_next = num[63] ? (64'd0 - num) : num;
  assign den_mag_next = den[DEN_W-1] ? (DEN_W'(0) - den) : den;
  assign invalid_next = (den == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      tp[0] <= in_data.temp;
      for (int i = 1; i < 7; i++) begin
        tp[i] <= tp[i-1];
      end
      rp[0] <= in_data.raw_press;
      for (int i = 1; i < 3; i++) begin
        rp[i] <= rp[i-1];
      end
      aa      <= aa_full[51:0];
      ap5     <= ap5_next;
      ap2     <= ap2_next;
      m6l     <= m6l_next;
      m6h     <= m6h_next;
      m3l     <= m3l_next;
      m3h     <= m3h_next;
      ap5_2   <= ap5;
      ap2_2   <= ap2;
      b       <= b_next;
      s3      <= s3_next;
      ap2_3   <= ap2_2;
      x       <= x_next;
      pn      <= pn_next;
      xl_p1   <= xl_p1_next;
      xh_p1   <= xh_p1_next;
      nl_k    <= nl_k_next;
      nh_k    <= nh_k_next;
      num     <= num_next;
      den     <= den_next;
      num_mag <= num_mag_next;
      den_mag <= den_mag_next;
      neg     <= neg_next;
      invalid <= invalid_next;
    end
  end

  assign out_vld          = vld[6];
  assign out_data.num_mag = num_mag;
  assign out_data.den_mag = den_mag;
  assign out_data.neg     = neg;
  assign out_data.invalid = invalid;
  assign out_data.temp    = tp[6];

endmodule

// File: rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div: pipelined restoring divider
// One quotient bit per stage. The dividend bits leave the top of a shift
// word while quotient bits enter at the bottom.
// ----------------------------------------------------------------------------
module ptc_div import ptc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_vld,
  input  ptc_dvop_t in_data,
  output logic      out_vld,
  output ptc_quo_t  out_data
);

  logic [DIV_STEPS-1:0] vld;
  logic [DEN_W-1:0]   rem  [1:DIV_STEPS];
  logic [63:0]        nq   [1:DIV_STEPS];
  logic [DEN_W-1:0]   den  [1:DIV_STEPS];
  logic               neg  [1:DIV_STEPS];
  logic               inv  [1:DIV_STEPS];
  logic signed [31:0] temp [1:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_vld};
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [DEN_W-1:0]   rem_c, den_c;
    logic [63:0]        nq_c;
    logic               neg_c, inv_c;
    logic signed [31:0] temp_c;
    logic [DEN_W:0]     trial, diff;
    logic               take;

    if (i == 0) begin : g_head
      assign rem_c  = '0;
      assign nq_c   = in_data.num_mag;
      assign den_c  = in_data.den_mag;
      assign neg_c  = in_data.neg;
      assign inv_c  = in_data.invalid;
      assign temp_c = in_data.temp;
    end else begin : g_body
      assign rem_c  = rem[i];
      assign nq_c   = nq[i];
      assign den_c  = den[i];
      assign neg_c  = neg[i];
      assign inv_c  = inv[i];
      assign temp_c = temp[i];
    end

    assign trial = {rem_c, nq_c[63]};
    assign diff  = trial - {1'b0, den_c};
    assign take  = (trial >= {1'b0, den_c});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq[i+1]   <= {nq_c[62:0], take};
        den[i+1]  <= den_c;
        neg[i+1]  <= neg_c;
        inv[i+1]  <= inv_c;
        temp[i+1] <= temp_c;
      end
    end
  end

  assign out_vld          = vld[DIV_STEPS-1];
  assign out_data.quo     = nq[DIV_STEPS];
  assign out_data.neg     = neg[DIV_STEPS];
  assign out_data.invalid = inv[DIV_STEPS];
  assign out_data.temp    = temp[DIV_STEPS];

endmodule

// File: rtl/ptc_post.sv
// ----------------------------------------------------------------------------
// ptc_post: pressure correction pipeline
// Applies the quotient sign, the P9 and P8 corrections and the P7 offset,
// and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module ptc_post import ptc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_vld,
  input  ptc_quo_t   in_data,
  input  ptc_calib_t calib,
  output logic       out_vld,
  output ptc_out_t   out_data
);

  logic [6:0] vld;
  logic signed [31:0] tp  [6];
  logic               inv [6];
  logic [63:0]        pp  [5];

  logic [63:0] p_next;
  logic signed [63:0] q;
  logic [63:0] qq_ll, qq_ll_next, qq_lh_full;
  logic [30:0] qq_lh, qq_lh_next;
  logic signed [48:0] pl8, pl8_next, ph8_full;
  logic [31:0] ph8, ph8_next;
  logic [63:0] m, m_next;
  logic signed [63:0] c2_sum;
  logic [63:0] c2, c2_next, c2_4, c2_5;
  logic signed [48:0] ml9, ml9_next, mh9_full;
  logic [31:0] mh9, mh9_next;
  logic signed [63:0] c1_sum;
  logic [63:0] c1, c1_next;
  logic [63:0] s, s_next;
  logic [31:0] press;
  ptc_out_t    res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_vld};
    end
  end

  assign p_next = in_data.neg ? (64'd0 - in_data.quo) : in_data.quo;

  // The square of p >> 13 is taken mod 2^64 from 32-bit halves.
  assign q          = $signed(pp[0]) >>> 13;
  assign qq_ll_next = q[31:0] * q[31:0];
  assign qq_lh_full = q[31:0] * q[63:32];
  assign qq_lh_next = qq_lh_full[30:0];
  assign pl8_next   = $signed({1'b0, pp[0][31:0]}) * $signed(calib.p8);
  assign ph8_full   = $signed({1'b0, pp[0][63:32]}) * $signed(calib.p8);
  assign ph8_next   = ph8_full[31:0];

  assign m_next  = qq_ll + {qq_lh, 33'd0};
  assign c2_sum  = {{15{pl8[48]}}, pl8} + {ph8, 32'd0};
  assign c2_next = c2_sum >>> 19;

  assign ml9_next = $signed({1'b0, m[31:0]}) * $signed(calib.p9);
  assign mh9_full = $signed({1'b0, m[63:32]}) * $signed(calib.p9);
  assign mh9_next = mh9_full[31:0];

  assign c1_sum  = {{15{ml9[48]}}, ml9} + {mh9, 32'd0};
  assign c1_next = c1_sum >>> 25;

  assign s_next = pp[4] + c1 + c2_5;

  assign press = s[39:8] + {{12{calib.p7[15]}}, calib.p7, 4'd0};
  assign res_next.temp_centi    = tp[5];
  assign res_next.press_value   = inv[5] ? 32'd0 : press;
  assign res_next.press_invalid = inv[5];

  always_ff @(posedge clk) begin
    if (en) begin
      tp[0]  <= in_data.temp;
      inv[0] <= in_data.invalid;
      for (int i = 1; i < 6; i++) begin
        tp[i]  <= tp[i-1];
        inv[i] <= inv[i-1];
      end
      pp[0] <= p_next;
      for (int i = 1; i < 5; i++) begin
        pp[i] <= pp[i-1];
      end
      qq_ll <= qq_ll_next;
      qq_lh <= qq_lh_next;
      pl8   <= pl8_next;
      ph8   <= ph8_next;
      m     <= m_next;
      c2    <= c2_next;
      c2_4  <= c2;
      c2_5  <= c2_4;
      ml9   <= ml9_next;
      mh9   <= mh9_next;
      c1    <= c1_next;
      s     <= s_next;
      res   <= res_next;
    end
  end

  assign out_vld  = vld[6];
  assign out_data = res;

endmodule

// File: rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: 64-bit integer sensor compensation
// Turns raw temperature and pressure readings into compensated values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one request per cycle,
//   a pair of raw 20-bit readings. Output channel (out_valid/out_ready/
//   out_data) returns temperature in 0.01 degC, the pressure word and a flag
//   that marks a zero divisor, where the pressure word is 0.
//   Calibration is loaded through cfg_we/cfg_index/cfg_wdata, by the user
//   only while no request is in flight; the block does not enforce this.
//   Writes take effect at the clock edge. The pipeline has 5 temperature
//   stages, 7 coefficient stages, 64 divider stages (one quotient bit each)
//   and 7 correction stages, the last being the output register.
//   Throughput is one request per cycle. The whole pipeline advances
//   together; while a result waits in the output register with out_ready
//   low, everything holds and in_ready is low.
//   Reset clears all valid bits and the calibration registers.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ptc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ptc_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [47:0] cal_temp;
  logic [63:0] cal_plo, cal_phi;
  logic [15:0] cal_p9;
  ptc_calib_t  calib;

  logic      adv;
  logic      tmp_vld, dv_vld, quo_vld;
  ptc_tmp_t  tmp_data;
  ptc_dvop_t dv_data;
  ptc_quo_t  quo_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp <= '0;
      cal_plo  <= '0;
      cal_phi  <= '0;
      cal_p9   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CALIB_TEMP: cal_temp <= cfg_wdata[47:0];
        REG_PRESS_LOW:  cal_plo  <= cfg_wdata;
        REG_PRESS_HIGH: cal_phi  <= cfg_wdata;
        REG_PRESS_LAST: cal_p9   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    calib.t1 = cal_temp[15:0];
    calib.t2 = cal_temp[31:16];
    calib.t3 = cal_temp[47:32];
    calib.p1 = cal_plo[15:0];
    calib.p2 = cal_plo[31:16];
    calib.p3 = cal_plo[47:32];
    calib.p4 = cal_plo[63:48];
    calib.p5 = cal_phi[15:0];
    calib.p6 = cal_phi[31:16];
    calib.p7 = cal_phi[47:32];
    calib.p8 = cal_phi[63:48];
    calib.p9 = cal_p9;
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  ptc_temp u_temp (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(in_valid && in_ready), .in_data(in_data), .calib(calib),
    .out_vld(tmp_vld), .out_data(tmp_data)
  );

  ptc_coef u_coef (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(tmp_vld), .in_data(tmp_data), .calib(calib),
    .out_vld(dv_vld), .out_data(dv_data)
  );

  ptc_div u_div (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(dv_vld), .in_data(dv_data),
    .out_vld(quo_vld), .out_data(quo_data)
  );

  ptc_post u_post (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(quo_vld), .in_data(quo_data), .calib(calib),
    .out_vld(out_valid), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.press_invalid |-> out_data.press_value == 32'd0)
    else $error("pressure not forced to zero on a zero divisor");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.temp_centi[31:19] == 13'd0) ||
                  (out_data.temp_centi[31:19] == 13'h1fff))
    else $error("temperature result outside its 20-bit range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
